FILE: src/dca_pkg.sv
package dca_pkg;

   localparam int NUM_CHANNELS = 32;
   localparam int NUM_SOURCES  = 64;

   // Fixed field widths of the ports
   localparam int FUNC_W    = 1;
   localparam int SRC_W     = 6;
   localparam int CHANNEL_W = 6;
   localparam int STATUS_W  = 2;

   // Derived internal widths
   localparam int CH_IDX_W  = $clog2(NUM_CHANNELS);
   localparam int CH_NUM_W  = $clog2(NUM_CHANNELS + 1);
   localparam int SRC_IDX_W = $clog2(NUM_SOURCES);

   localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } dca_state_type;

   typedef struct packed {
      logic                hit;
      logic [CH_IDX_W-1:0] idx;
   } free_slot_type;

endpackage

FILE: src/dca_ram.sv
module dca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/dca_find_free.sv
module dca_find_free import dca_pkg::*; (
   input  logic [NUM_CHANNELS-1:0] used_map,
   output free_slot_type           slot
);

   // Scan from the top down so the lowest free channel wins.
   always_comb begin
      slot.hit = 1'b0;
      slot.idx = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!used_map[i]) begin
            slot.hit = 1'b1;
            slot.idx = CH_IDX_W'(i);
         end
      end
   end

endmodule

FILE: src/dma_channel_allocator.sv
// DMA channel allocator. Pulse start with req_func (0 request, 1 release) and
// req_request_id while busy is low; the item is taken at that edge. Each item
// gives exactly one result, registered out of the EXEC state: rsp_valid is high for
// a single cycle with rsp_channel (1 to 32, 0 if none) and rsp_status (0 done,
// 1 no free channel, 2 source holds no channel). The receiver cannot stall, so
// sample the result in the cycle rsp_valid is high. The pace of an item is
// set by the registered read of the source-to-channel table RAM: busy
// stays high in the cycle after acceptance while the table entry is read,
// modified and written back, and a new item is taken in the cycle the result
// is shown. A request takes the lowest free channel and overwrites any record
// the source already held; a release frees the recorded channel.
module dma_channel_allocator import dca_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [SRC_W-1:0]     req_request_id,
   output logic                 rsp_valid,
   output logic [CHANNEL_W-1:0] rsp_channel,
   output logic [STATUS_W-1:0]  rsp_status
);

   dca_state_type state_ff, state_in;

   logic                    accept;
   logic [FUNC_W-1:0]       func_ff;
   logic [SRC_W-1:0]        src_ff;
   logic                    entry_valid_ff;
   logic [NUM_SOURCES-1:0]  valid_ff, valid_in;
   logic [NUM_CHANNELS-1:0] used_map_ff, used_map_in;

   logic                    ram_wr_en;
   logic [CH_NUM_W-1:0]     ram_wr_data;
   logic [CH_NUM_W-1:0]     ram_rd_data;
   logic [SRC_IDX_W-1:0]    src_idx;

   logic [CH_NUM_W-1:0]     entry;
   logic [CH_NUM_W-1:0]     grant_num;
   logic [CH_IDX_W-1:0]     release_idx;
   logic                    src_ok;
   free_slot_type           free_slot;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0]    rsp_channel_ff, rsp_channel_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_EXEC: busy = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   assign accept = start && !busy;

   // Source table: one entry per source, read at accept, written back in EXEC
   dca_ram #(
      .WIDTH (CH_NUM_W),
      .DEPTH (NUM_SOURCES)
   ) u_src_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (SRC_IDX_W'(src_ff)),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (src_idx),
      .rd_data (ram_rd_data)
   );

   assign src_idx = SRC_IDX_W'(req_request_id);

   dca_find_free u_find_free (
      .used_map (used_map_ff),
      .slot     (free_slot)
   );

   // An entry never written since reset reads as "no channel".
   assign entry       = entry_valid_ff ? ram_rd_data : '0;
   assign grant_num   = CH_NUM_W'(free_slot.idx) + CH_NUM_W'(1);
   assign release_idx = CH_IDX_W'(entry - CH_NUM_W'(1));
   assign src_ok      = int'(src_ff) < NUM_SOURCES;

   // Read-modify-write of the table entry and the busy map
   always_comb begin
      ram_wr_en      = 1'b0;
      ram_wr_data    = '0;
      used_map_in    = used_map_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = 1'b0;
      rsp_channel_in = '0;
      rsp_status_in  = STATUS_DONE;
      if (state_ff == ST_EXEC) begin
         rsp_valid_in = 1'b1;
         if (!src_ok) begin
            rsp_status_in = STATUS_NOT_MAPPED;
         end else if (func_ff == FUNC_REQUEST) begin
            if (free_slot.hit) begin
               // Claim the lowest free channel; any older record is dropped.
               used_map_in[free_slot.idx] = 1'b1;
               ram_wr_en      = 1'b1;
               ram_wr_data    = grant_num;
               rsp_channel_in = CHANNEL_W'(grant_num);
            end else begin
               rsp_status_in = STATUS_NO_FREE;
            end
         end else begin
            if (entry == '0 || int'(entry) > NUM_CHANNELS) begin
               rsp_status_in = STATUS_NOT_MAPPED;
            end else begin
               // Free the recorded channel and clear the record.
               used_map_in[release_idx] = 1'b0;
               ram_wr_en      = 1'b1;
               ram_wr_data    = '0;
               rsp_channel_in = CHANNEL_W'(entry);
            end
         end
         if (ram_wr_en) begin
            valid_in[SRC_IDX_W'(src_ff)] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_map_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_map_ff  <= used_map_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the item's fields for the EXEC cycle; advance result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff        <= req_func;
         src_ff         <= req_request_id;
         entry_valid_ff <= valid_ff[src_idx];
      end
      rsp_channel_ff <= rsp_channel_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import dca_pkg::*;

   // Expected outcome of one item: the channel number and the status code
   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [STATUS_W-1:0]  status;
   } alloc_result_type;

   localparam int MAX_LEAKS   = 6;    // channels lost to re-requests, never freed again
   localparam int RANDOM_ITEMS = 800;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic [FUNC_W-1:0]    req_func       = FUNC_REQUEST;
   logic [SRC_W-1:0]     req_request_id = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [CHANNEL_W-1:0] rsp_channel;
   logic [STATUS_W-1:0]  rsp_status;

   dma_channel_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_request_id (req_request_id),
      .rsp_valid      (rsp_valid),
      .rsp_channel    (rsp_channel),
      .rsp_status     (rsp_status)
   );

   always #2 clock = ~clock;

   // Predictor state: busy-channel bitmap and source-to-channel table (0 = none)
   logic [NUM_CHANNELS-1:0] chan_busy_map = '0;
   logic [CHANNEL_W-1:0]    src_chan [NUM_SOURCES];
   alloc_result_type        pending_grants [$];
   int                      mismatch_count = 0;

   // Stimulus-side bookkeeping, kept apart from the predictor so that the
   // choice of the next item never races with the checker at a clock edge
   bit holds_chan [NUM_SOURCES];
   int free_left  = NUM_CHANNELS;
   int leak_count = 0;
   bit calm       = 1'b0;  // suppress idle gaps

   initial begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
         src_chan[s]   = '0;
         holds_chan[s] = 1'b0;
      end
   end

   function automatic void note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR @%0t: %s", $time, msg);
   endfunction

   // Apply one item to the predictor state and return what the block must answer
   function automatic alloc_result_type predict_alloc(input logic [FUNC_W-1:0] func,
                                                      input logic [SRC_W-1:0]  src);
      alloc_result_type res;
      bit               found;
      res.channel = '0;
      res.status  = STATUS_NO_FREE;
      found       = 1'b0;
      if (func == FUNC_REQUEST) begin
         // take the lowest free channel; a record already held is overwritten
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!found && !chan_busy_map[i]) begin
               found            = 1'b1;
               chan_busy_map[i] = 1'b1;
               src_chan[src]    = CHANNEL_W'(i + 1);
               res.channel      = CHANNEL_W'(i + 1);
               res.status       = STATUS_DONE;
            end
         end
      end else if (src_chan[src] == '0) begin
         res.status = STATUS_NOT_MAPPED;
      end else begin
         chan_busy_map[src_chan[src] - 1] = 1'b0;
         res.channel   = src_chan[src];
         res.status    = STATUS_DONE;
         src_chan[src] = '0;
      end
      return res;
   endfunction

   // Checker: record each accepted item, compare each result with the oldest
   // expectation. Values read here are those from before the edge.
   always @(posedge clock) begin : result_check
      alloc_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               note_error($sformatf("result with nothing pending: channel=%0d status=%0d",
                                    rsp_channel, rsp_status));
            end else begin
               want = pending_grants.pop_front();
               if (rsp_channel !== want.channel || rsp_status !== want.status)
                  note_error($sformatf("channel exp %0d got %0d, status exp %0d got %0d",
                                       want.channel, rsp_channel, want.status, rsp_status));
            end
         end
         if (start && !busy)
            pending_grants.push_back(predict_alloc(req_func, req_request_id));
      end
   end

   // Present one item and hold it until the block takes it. Leave start high
   // after the accepting edge unless an idle gap follows, so back-to-back
   // items never see start dropped and raised in the same step.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SRC_W-1:0] src);
      req_func       <= func;
      req_request_id <= src;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      if (!calm && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Request wrapper: track pool occupancy and leaked channels for stimulus choices
   task automatic issue_request(input int src);
      if (free_left > 0) begin
         free_left--;
         if (holds_chan[src])
            leak_count++;
         holds_chan[src] = 1'b1;
      end
      send_item(FUNC_REQUEST, SRC_W'(src));
   endtask

   task automatic issue_release(input int src);
      if (holds_chan[src]) begin
         holds_chan[src] = 1'b0;
         free_left++;
      end
      send_item(FUNC_RELEASE, SRC_W'(src));
   endtask

   function automatic int pick_source(input bit holder);
      int s;
      do s = $urandom_range(0, NUM_SOURCES - 1); while (holds_chan[s] != holder);
      return s;
   endfunction

   function automatic int holder_total();
      int n = 0;
      for (int s = 0; s < NUM_SOURCES; s++)
         n += holds_chan[s];
      return n;
   endfunction

   // Grant and free at both ends of the source range; reuse of the lowest hole
   task automatic test_request_release();
      issue_request(0);
      issue_request(NUM_SOURCES - 1);
      issue_release(0);
      issue_request(5);           // refill the hole left by source 0
      issue_release(NUM_SOURCES - 1);
      issue_release(5);
   endtask

   // Release from a source that never held a channel, and a second release
   task automatic test_release_unmapped();
      issue_release(17);
      issue_request(0);
      issue_release(0);
      issue_release(0);
   endtask

   // A source asking twice keeps only its newest channel; the first stays busy
   task automatic test_rerequest_overwrite();
      issue_request(9);
      issue_request(9);
      issue_release(9);
      issue_release(9);
   endtask

   // Drain the pool, knock on it while full, then hand back about half
   task automatic test_pool_exhaustion();
      int n_back;
      while (free_left > 0)
         issue_request(pick_source(1'b0));
      issue_request(pick_source(1'b0));
      issue_request(pick_source(1'b1));   // holder asking while full: no change
      issue_request(pick_source(1'b0));
      n_back = holder_total() / 2;
      repeat (n_back)
         issue_release(pick_source(1'b1));
   endtask

   // Mostly well-formed traffic (requests from idle sources, releases from
   // holders) under a shifting request bias so the pool swings between
   // empty and full; the rest is noise: stray releases and re-requests.
   task automatic test_random_traffic(input int n_items);
      int req_pct;
      int roll;
      req_pct = 50;
      for (int k = 0; k < n_items; k++) begin
         calm = (k >= n_items / 3 && k < n_items / 2);
         if (k % 48 == 0) begin
            case ($urandom_range(0, 3))
               0: req_pct = 15;
               1: req_pct = 50;
               2: req_pct = 85;
               default: req_pct = 97;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            issue_release(pick_source(1'b0));
         end else if (roll < 7 && leak_count < MAX_LEAKS && holder_total() > 0) begin
            issue_request(pick_source(1'b1));
         end else if (holder_total() == 0 || $urandom_range(0, 99) < req_pct) begin
            issue_request(pick_source(1'b0));
         end else begin
            issue_release(pick_source(1'b1));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      int guard;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_request_release();
      test_release_unmapped();
      test_rerequest_overwrite();
      test_pool_exhaustion();
      test_random_traffic(RANDOM_ITEMS);

      start <= 1'b0;
      guard = 0;
      while (pending_grants.size() != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
      repeat (6) @(posedge clock);

      if (pending_grants.size() != 0)
         note_error($sformatf("%0d results never arrived", pending_grants.size()));

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
